// ----- src/lcd_serial_frame_writer_core_assert.svh -----
// concurrent assertion macros, sampled on clk_i and disabled in reset
`ifndef LCD_SERIAL_FRAME_WRITER_CORE_ASSERT_SVH
`define LCD_SERIAL_FRAME_WRITER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LSFW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsfw assertion failed");
`define LSFW_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define LSFW_ASSERT(lbl, prop)
`define LSFW_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

// ----- src/lsfw_pkg.sv -----
`default_nettype none
package lsfw_pkg;

  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned FrameW = 24;
  localparam int unsigned FrameBits = 24;
  localparam int unsigned GraphicFrames = 6;

  localparam logic [7:0] SYNC_INSTR    = 8'hF8;
  localparam logic [7:0] SYNC_DATA     = 8'hFA;
  localparam logic [7:0] ADDR_BASE     = 8'h80;
  localparam logic [7:0] MODE_EXTENDED = 8'h36;
  localparam logic [7:0] MODE_BASIC    = 8'h30;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
  localparam logic [15:0] FRAME_GAP_RESET   = 16'd7500;

  typedef enum logic [1:0] {
    CMD_INSTR   = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_GRAPHIC = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_HALF_PERIOD = 1'b0,
    CFG_FRAME_GAP   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              last;
    logic [FrameW-1:0] frame;
  } frame_item_t;

  typedef struct packed {
    logic select_level;
    logic shifting;
  } bk_status_t;

  // sync byte, high nibble then 0000, low nibble then 0000
  function automatic logic [FrameW-1:0] make_frame(input logic is_data, input logic [7:0] b);
    logic [7:0] sync;
    sync = is_data ? SYNC_DATA : SYNC_INSTR;
    return {sync, b[7:4], 4'b0000, b[3:0], 4'b0000};
  endfunction

endpackage
`default_nettype wire

// ----- src/lsfw_front.sv -----
`default_nettype none
module lsfw_front
  import lsfw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [7:0]  low_byte_i,
  input  wire logic [5:0]  row_i,
  input  wire logic [2:0]  column_i,
  input  wire logic        full_i,
  output logic             push_o,
  output frame_item_t      push_item_o,
  output logic             busy_o
);

  localparam logic [2:0] LastIdx = 3'(GraphicFrames - 1);

  logic       busy_q, busy_d;
  logic       graphic_q, graphic_d;
  logic       is_data_q, is_data_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_q, byte_d;
  logic [7:0] low_q, low_d;
  logic [5:0] row_q, row_d;
  logic [2:0] col_q, col_d;
  logic       accept, last, done, valid_cmd;
  logic [7:0] row_addr, col_addr;

  // rows of the lower half go to bank 8
  assign row_addr = ADDR_BASE | {3'b000, row_q[4:0]};
  assign col_addr = ADDR_BASE | {4'b0000, row_q[5], col_q};

  always_comb begin
    push_item_o.last  = last;
    push_item_o.frame = make_frame(is_data_q, byte_q);
    if (graphic_q) begin
      unique case (idx_q)
        3'd0:    push_item_o.frame = make_frame(1'b0, MODE_EXTENDED);
        3'd1:    push_item_o.frame = make_frame(1'b0, row_addr);
        3'd2:    push_item_o.frame = make_frame(1'b0, col_addr);
        3'd3:    push_item_o.frame = make_frame(1'b1, byte_q);
        3'd4:    push_item_o.frame = make_frame(1'b1, low_q);
        default: push_item_o.frame = make_frame(1'b0, MODE_BASIC);
      endcase
    end
  end

  assign last             = graphic_q ? (idx_q == LastIdx) : 1'b1;
  assign push_o           = busy_q && !full_i;
  assign done             = push_o && last;
  assign in_ready_o       = !busy_q || done;
  assign accept           = in_valid_i && in_ready_o;
  assign busy_o           = busy_q;

  always_comb begin
    valid_cmd = 1'b1;
    is_data_d = 1'b0;
    graphic_d = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_INSTR:   is_data_d = 1'b0;
      CMD_DATA:    is_data_d = 1'b1;
      CMD_GRAPHIC: graphic_d = 1'b1;
      default:     valid_cmd = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    byte_d = byte_q;
    low_d  = low_q;
    row_d  = row_q;
    col_d  = col_q;
    if (accept) begin
      busy_d = valid_cmd;
      idx_d  = '0;
      byte_d = byte_value_i;
      low_d  = low_byte_i;
      row_d  = row_i;
      col_d  = column_i;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (push_o) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      graphic_q <= graphic_d;
      is_data_q <= is_data_d;
    end
    byte_q <= byte_d;
    low_q  <= low_d;
    row_q  <= row_d;
    col_q  <= col_d;
  end

endmodule
`default_nettype wire

// ----- src/lsfw_queue.sv -----
`default_nettype none
module lsfw_queue
  import lsfw_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire frame_item_t push_item_i,
  output logic       full_o,
  output logic       head_valid_o,
  output frame_item_t head_item_o,
  input  wire logic  pop_i
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  frame_item_t      mem_q [Depth];
  frame_item_t      head_q;
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             head_valid_q, head_valid_d;
  logic             load;

  assign full_o       = (count_q == CntW'(Depth));
  assign load         = (count_q != '0) && (!head_valid_q || pop_i);
  assign head_valid_o = head_valid_q;
  assign head_item_o  = head_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
    if (load)   rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
    count_d = count_q + CntW'(push_i) - CntW'(load);
    head_valid_d = head_valid_q;
    if (load)       head_valid_d = 1'b1;
    else if (pop_i) head_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i) begin
    if (load) head_q <= mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      head_valid_q <= 1'b0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      count_q      <= count_d;
      head_valid_q <= head_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/lsfw_back.sv -----
`default_nettype none
module lsfw_back
  import lsfw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] half_period_i,
  input  wire logic [15:0] frame_gap_i,
  input  wire logic        head_valid_i,
  input  wire frame_item_t head_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output frame_item_t      out_item_o,
  output bk_status_t       status_o
);

  localparam logic [4:0] LastBit = 5'(FrameBits - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_GAP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [FrameW-1:0] shift_word_q, shift_word_d;
  logic [4:0]        bit_count_q, bit_count_d;
  logic [15:0]       timing_count_q, timing_count_d;
  logic              phase_q, phase_d;
  logic              select_q, select_d;
  frame_item_t       cur_q, cur_d;
  logic              out_valid_q, out_valid_d;
  frame_item_t       out_q;
  logic              out_load, half_end;

  assign half_end = (timing_count_q == half_period_i - 16'd1);

  always_comb begin
    state_d        = state_q;
    shift_word_d   = shift_word_q;
    bit_count_d    = bit_count_q;
    timing_count_d = timing_count_q;
    phase_d        = phase_q;
    select_d       = select_q;
    cur_d          = cur_q;
    pop_o          = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o          = 1'b1;
          cur_d          = head_item_i;
          shift_word_d   = head_item_i.frame;
          bit_count_d    = '0;
          timing_count_d = '0;
          phase_d        = 1'b0;
          select_d       = 1'b1;
          state_d        = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (half_end) begin
          timing_count_d = '0;
          phase_d        = !phase_q;
          if (phase_q) begin
            shift_word_d = {shift_word_q[FrameW-2:0], 1'b0};
            bit_count_d  = bit_count_q + 5'd1;
            if (bit_count_q == LastBit) begin
              select_d    = 1'b0;
              bit_count_d = '0;
              state_d     = (frame_gap_i == '0) ? ST_DONE : ST_GAP;
            end
          end
        end else begin
          timing_count_d = timing_count_q + 16'd1;
        end
      end
      ST_GAP: begin
        if (timing_count_q == frame_gap_i - 16'd1) begin
          timing_count_d = '0;
          state_d        = ST_DONE;
        end else begin
          timing_count_d = timing_count_q + 16'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o           = out_valid_q;
  assign out_item_o            = out_q;
  assign status_o.select_level = select_q;
  assign status_o.shifting     = (state_q == ST_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      shift_word_q   <= '0;
      bit_count_q    <= '0;
      timing_count_q <= '0;
      phase_q        <= 1'b0;
      select_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      shift_word_q   <= shift_word_d;
      bit_count_q    <= bit_count_d;
      timing_count_q <= timing_count_d;
      phase_q        <= phase_d;
      select_q       <= select_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (out_load) out_q <= cur_q;
  end

endmodule
`default_nettype wire

// ----- src/lcd_serial_frame_writer_core.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tdata: byte_value, low_byte, row, column
//                                               tuser: cmd
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: frame, tlast: is_last
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// the serializer shifts each frame out bit by bit at the set half period, then waits the frame gap;
// an instruction or data item gives one frame, a graphic write six
// the front expands one frame per cycle into the queue, unless the queue is full, while the serializer works
// reset is asynchronous active low; control and the queue pointers clear at once
// a stalled result output blocks only the serializer once its frame is sent
`default_nettype none
`include "lcd_serial_frame_writer_core_assert.svh"
module lcd_serial_frame_writer_core
  import lsfw_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] byte_value, [15:8] low_byte, [21:16] row, [24:22] column, [31:25] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [23:0] frame
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] half_period_q, frame_gap_q;
  logic        q_push, q_full, q_head_valid, q_pop, fe_busy;
  frame_item_t q_push_item, q_head_item, out_item;
  bk_status_t  bk_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
      frame_gap_q   <= FRAME_GAP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HALF_PERIOD: half_period_q <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
        CFG_FRAME_GAP:   frame_gap_q   <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  lsfw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cmd_i        (s_axis_tuser_i),
    .byte_value_i (s_axis_tdata_i[7:0]),
    .low_byte_i   (s_axis_tdata_i[15:8]),
    .row_i        (s_axis_tdata_i[21:16]),
    .column_i     (s_axis_tdata_i[24:22]),
    .full_i       (q_full),
    .push_o       (q_push),
    .push_item_o  (q_push_item),
    .busy_o       (fe_busy)
  );

  lsfw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (q_push_item),
    .full_o       (q_full),
    .head_valid_o (q_head_valid),
    .head_item_o  (q_head_item),
    .pop_i        (q_pop)
  );

  lsfw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_period_i (half_period_q),
    .frame_gap_i   (frame_gap_q),
    .head_valid_i  (q_head_valid),
    .head_item_i   (q_head_item),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_item_o    (out_item),
    .status_o      (bk_status)
  );

  assign m_axis_tdata_o = out_item.frame;
  assign m_axis_tlast_o = out_item.last;

  `LSFW_ASSERT(a_no_push_when_full, q_push |-> !q_full)
  `LSFW_ASSERT(a_select_only_shifting, bk_status.select_level |-> bk_status.shifting)
  `LSFW_ASSERT_MSG(a_graphic_keeps_front_busy,
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == CMD_GRAPHIC)) |=> fe_busy,
    "graphic write not held by front")
  `LSFW_ASSERT(a_pop_needs_head, q_pop |-> q_head_valid)

endmodule
`default_nettype wire
